/* hdl/nidt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidt_pkg
// Shared types, constants and codes of the nearest instance damage table.
// ----------------------------------------------------------------------------
package nidt_pkg;

  // table geometry
  localparam int MAX_INSTANCES = 256;
  localparam int COORD_BITS    = 24;
  localparam int ADDR_BITS     = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int CNT_BITS      = $clog2(MAX_INSTANCES + 1);

  // field widths
  localparam int SLOT_BITS   = 8;
  localparam int HEALTH_BITS = 24;
  localparam int DAMAGE_BITS = 23;
  localparam int COUNT_BITS  = 9;
  localparam int START_BITS  = 23;
  localparam int CFG_BITS    = 23;

  // distance arithmetic
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int SQ_BITS   = 2 * DIFF_BITS;
  localparam int DIST_BITS = SQ_BITS + 2;
  localparam int POS_BITS  = 3 * COORD_BITS;

  // stream widths
  localparam int S_TDATA_BITS = 104;
  localparam int M_TDATA_BITS = 32;
  localparam int M_TUSER_BITS = 3;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_INSTANCE_COUNT = 1'b0,
    CFG_START_HEALTH   = 1'b1
  } cfg_index_t;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_LOADED    = 3'd0,
    STATUS_DAMAGED   = 3'd1,
    STATUS_DESTROYED = 3'd2,
    STATUS_ALREADY   = 3'd3,
    STATUS_NONE      = 3'd4
  } status_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_HREAD,
    BK_HAPPLY
  } back_state_t;

  // one classified item in the queue
  typedef struct packed {
    logic                   is_hit;
    logic [SLOT_BITS-1:0]   slot;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [COORD_BITS-1:0]  pos_z;
    logic [DAMAGE_BITS-1:0] damage;
  } item_t;

  // one result beat
  typedef struct packed {
    status_t                status;
    logic [SLOT_BITS-1:0]   closest_slot;
    logic [HEALTH_BITS-1:0] health_left;
  } result_t;

endpackage

/* hdl/nearest_instance_damage_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_instance_damage_table
// Table of instance positions and healths with nearest-hit damage update.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one beat per item. tuser 0 loads a position into entry slot
//   and gives it start_health; tuser 1 applies damage to the stored entry
//   nearest (squared distance, lowest index on ties) to the point.
//   m_* returns exactly one beat per item, in order.
//   cfg_we/cfg_index/cfg_data write instance_count (index 0) and
//   start_health (index 1); write only while the block is idle.
// Execution:
//   a load, or a hit with no instances, is answered from the idle state; a
//   hit scans n = min(instance_count, table size) stored entries, read from the
//   position memory read port, which delivers one stored entry per cycle to a
//   four-stage distance pipeline, then reads the winner's health and applies the damage.
//   The next item starts the cycle after the result beat is taken.
//   A two-entry queue takes input beats while a result waits or a scan runs.
// Reset: rst clears the queue, the sequencer and the output valid and sets
//   instance_count 0, start_health 25600; the stores are undefined until
//   loaded. A stalled receiver holds the result beat; the next item waits.
// ----------------------------------------------------------------------------
module nearest_instance_damage_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // slot[7:0], pos_x[31:8], pos_y[55:32], pos_z[79:56], damage[102:80], zero
  input  logic [nidt_pkg::S_TDATA_BITS-1:0] s_tdata,
  // action
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // closest_slot[7:0], health_left[31:8]
  output logic [nidt_pkg::M_TDATA_BITS-1:0] m_tdata,
  // status
  output logic [nidt_pkg::M_TUSER_BITS-1:0] m_tuser,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [nidt_pkg::CFG_BITS-1:0]     cfg_data
);

  logic [nidt_pkg::COUNT_BITS-1:0] instance_count;
  logic [nidt_pkg::START_BITS-1:0] start_health;
  logic                            q_valid;
  nidt_pkg::item_t                 q_item;
  logic                            q_pop;
  nidt_pkg::result_t               result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      instance_count <= '0;
      start_health   <= nidt_pkg::START_BITS'(25600);
    end else if (cfg_we) begin
      case (cfg_index)
        nidt_pkg::CFG_INSTANCE_COUNT: instance_count <= cfg_data[nidt_pkg::COUNT_BITS-1:0];
        nidt_pkg::CFG_START_HEALTH:   start_health   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  nidt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  nidt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .instance_count (instance_count),
    .start_health   (start_health),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_result     (result)
  );

  // result beat packing
  assign m_tuser = result.status;
  assign m_tdata = {result.health_left, result.closest_slot};

endmodule

/* hdl/nidt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidt_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nidt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/nidt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidt_front
// Input side: takes beats, splits the fields, queues items for the back end.
// ----------------------------------------------------------------------------
module nidt_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [nidt_pkg::S_TDATA_BITS-1:0]   s_tdata,
  input  logic                                s_tuser,
  output logic                                q_valid,
  output nidt_pkg::item_t                     q_item,
  input  logic                                q_pop
);

  nidt_pkg::item_t                      queue [nidt_pkg::QUEUE_DEPTH];
  logic [nidt_pkg::QPTR_BITS-1:0]       wr_ptr;
  logic [nidt_pkg::QPTR_BITS-1:0]       rd_ptr;
  logic [nidt_pkg::QCNT_BITS-1:0]       fill;
  nidt_pkg::item_t                      item_in;
  logic                                 push;
  logic                                 pop;

  // field split of the incoming beat
  always_comb begin
    item_in.is_hit = s_tuser;
    item_in.slot   = s_tdata[7:0];
    item_in.pos_x  = s_tdata[31:8];
    item_in.pos_y  = s_tdata[55:32];
    item_in.pos_z  = s_tdata[79:56];
    item_in.damage = s_tdata[102:80];
  end

  assign s_tready = (fill != nidt_pkg::QCNT_BITS'(nidt_pkg::QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = queue[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == nidt_pkg::QPTR_BITS'(nidt_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == nidt_pkg::QPTR_BITS'(nidt_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* hdl/nidt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidt_back
// Execution side: stores loads, runs the nearest entry scan and the damage
// update, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module nidt_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [nidt_pkg::COUNT_BITS-1:0]      instance_count,
  input  logic [nidt_pkg::START_BITS-1:0]      start_health,
  input  logic                                 q_valid,
  input  nidt_pkg::item_t                      q_item,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output nidt_pkg::result_t                    out_result
);

  localparam int AB = nidt_pkg::ADDR_BITS;
  localparam int CB = nidt_pkg::CNT_BITS;
  localparam int CO = nidt_pkg::COORD_BITS;
  localparam int DB = nidt_pkg::DIFF_BITS;
  localparam int HB = nidt_pkg::HEALTH_BITS;

  nidt_pkg::back_state_t       state, state_next;

  // latched hit item
  logic [CO-1:0]                      cur_x, cur_y, cur_z;
  logic [nidt_pkg::DAMAGE_BITS-1:0]   cur_damage;

  // scan control
  logic [CB-1:0]               cnt;
  logic [CB-1:0]               scan_n;
  logic                        issue;
  logic                        scan_start;

  // distance pipeline
  logic                        s1_valid, s2_valid, s3_valid, s4_valid;
  logic [AB-1:0]               s1_idx, s2_idx, s3_idx, s4_idx;
  logic [DB-1:0]               s2_dx, s2_dy, s2_dz;
  logic [nidt_pkg::SQ_BITS-1:0]   s3_sx, s3_sy, s3_sz;
  logic [nidt_pkg::DIST_BITS-1:0] s4_sum;
  logic                           best_valid;
  logic [nidt_pkg::DIST_BITS-1:0] best_dist;
  logic [AB-1:0]                  best_idx;

  // memories
  logic                          pos_we;
  logic [AB-1:0]                 pos_rd_addr;
  logic [nidt_pkg::POS_BITS-1:0] pos_rd_data;
  logic                          health_we;
  logic [AB-1:0]                 health_wr_addr;
  logic [HB-1:0]                 health_wr_data;
  logic [HB-1:0]                 health_rd_data;

  // health update
  logic                        alive;
  logic [HB:0]                 health_diff;
  logic [HB-1:0]               health_new;
  logic                        slot_ok;

  // result staging
  logic                        out_load;
  nidt_pkg::result_t           out_next;

  // scan length, clamped to the table size
  assign scan_n = (32'(instance_count) > nidt_pkg::MAX_INSTANCES) ?
                  CB'(nidt_pkg::MAX_INSTANCES) : CB'(instance_count);
  assign slot_ok = (32'(q_item.slot) < nidt_pkg::MAX_INSTANCES);

  assign issue       = (state == nidt_pkg::BK_SCAN) && (cnt < scan_n);
  assign pos_rd_addr = cnt[AB-1:0];

  // damage arithmetic on the stored health of the winner
  assign alive       = !health_rd_data[HB-1] && (health_rd_data != '0);
  assign health_diff = {health_rd_data[HB-1], health_rd_data} -
                       (HB+1)'(cur_damage);
  assign health_new  = (health_diff[HB] && !health_diff[HB-1]) ?
                       {1'b1, {(HB-1){1'b0}}} : health_diff[HB-1:0];

  // position and health stores
  nidt_ram #(.WIDTH(nidt_pkg::POS_BITS), .DEPTH(nidt_pkg::MAX_INSTANCES)) u_pos_ram (
    .clk     (clk),
    .we      (pos_we),
    .wr_addr (AB'(q_item.slot)),
    .wr_data ({q_item.pos_z, q_item.pos_y, q_item.pos_x}),
    .rd_addr (pos_rd_addr),
    .rd_data (pos_rd_data)
  );

  nidt_ram #(.WIDTH(HB), .DEPTH(nidt_pkg::MAX_INSTANCES)) u_health_ram (
    .clk     (clk),
    .we      (health_we),
    .wr_addr (health_wr_addr),
    .wr_data (health_wr_data),
    .rd_addr (best_idx),
    .rd_data (health_rd_data)
  );

  // sequencer: next state, queue pop, store writes and result staging
  always_comb begin
    state_next     = state;
    q_pop          = 1'b0;
    scan_start     = 1'b0;
    pos_we         = 1'b0;
    health_we      = 1'b0;
    health_wr_addr = best_idx;
    health_wr_data = health_new;
    out_load       = 1'b0;
    out_next       = '{status: nidt_pkg::STATUS_LOADED, closest_slot: '0,
                       health_left: '0};
    case (state)
      nidt_pkg::BK_IDLE: begin
        if (q_valid && !out_valid) begin
          q_pop    = 1'b1;
          if (!q_item.is_hit) begin
            pos_we         = slot_ok;
            health_we      = slot_ok;
            health_wr_addr = AB'(q_item.slot);
            health_wr_data = HB'(start_health);
            out_load       = 1'b1;
            out_next.status       = nidt_pkg::STATUS_LOADED;
            out_next.closest_slot = q_item.slot;
            out_next.health_left  = slot_ok ? HB'(start_health) : '0;
          end else if (scan_n == '0) begin
            out_load        = 1'b1;
            out_next.status = nidt_pkg::STATUS_NONE;
          end else begin
            scan_start = 1'b1;
            state_next = nidt_pkg::BK_SCAN;
          end
        end
      end
      nidt_pkg::BK_SCAN: begin
        if (!issue && !s1_valid && !s2_valid && !s3_valid && !s4_valid) begin
          state_next = nidt_pkg::BK_HREAD;
        end
      end
      nidt_pkg::BK_HREAD: begin
        state_next = nidt_pkg::BK_HAPPLY;
      end
      nidt_pkg::BK_HAPPLY: begin
        out_load              = 1'b1;
        out_next.closest_slot = nidt_pkg::SLOT_BITS'(best_idx);
        if (!alive) begin
          out_next.status      = nidt_pkg::STATUS_ALREADY;
          out_next.health_left = health_rd_data;
        end else begin
          health_we            = 1'b1;
          out_next.health_left = health_new;
          out_next.status      = (health_new[HB-1] || health_new == '0) ?
                                 nidt_pkg::STATUS_DESTROYED : nidt_pkg::STATUS_DAMAGED;
        end
        state_next = nidt_pkg::BK_IDLE;
      end
      default: begin
        state_next = nidt_pkg::BK_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nidt_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control flops of the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      s4_valid   <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      if (scan_start) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      if (scan_start) begin
        best_valid <= 1'b0;
      end else if (s4_valid) begin
        best_valid <= 1'b1;
      end
    end
  end

  // latch the hit point
  always_ff @(posedge clk) begin
    if (scan_start) begin
      cur_x      <= q_item.pos_x;
      cur_y      <= q_item.pos_y;
      cur_z      <= q_item.pos_z;
      cur_damage <= q_item.damage;
    end
  end

  // distance pipeline: absolute differences, squares, sum, running minimum
  always_ff @(posedge clk) begin : dist_pipe
    logic [DB-1:0] dx, dy, dz;
    dx = {cur_x[CO-1], cur_x} - {pos_rd_data[CO-1], pos_rd_data[CO-1:0]};
    dy = {cur_y[CO-1], cur_y} - {pos_rd_data[2*CO-1], pos_rd_data[2*CO-1:CO]};
    dz = {cur_z[CO-1], cur_z} - {pos_rd_data[3*CO-1], pos_rd_data[3*CO-1:2*CO]};
    s1_idx <= cnt[AB-1:0];
    s2_idx <= s1_idx;
    s2_dx  <= dx[DB-1] ? -dx : dx;
    s2_dy  <= dy[DB-1] ? -dy : dy;
    s2_dz  <= dz[DB-1] ? -dz : dz;
    s3_idx <= s2_idx;
    s3_sx  <= s2_dx * s2_dx;
    s3_sy  <= s2_dy * s2_dy;
    s3_sz  <= s2_dz * s2_dz;
    s4_idx <= s3_idx;
    s4_sum <= nidt_pkg::DIST_BITS'(s3_sx) + nidt_pkg::DIST_BITS'(s3_sy) +
              nidt_pkg::DIST_BITS'(s3_sz);
    // strict compare keeps the lowest index on equal distances
    if (s4_valid && (!best_valid || s4_sum < best_dist)) begin
      best_dist <= s4_sum;
      best_idx  <= s4_idx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= out_next;
    end
  end

endmodule

/* hdl/nidt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nidt_checker
// Port-level checks of the nearest instance damage table, bound to the top.
// ----------------------------------------------------------------------------
module nidt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [nidt_pkg::M_TDATA_BITS-1:0] m_tdata,
  input logic [nidt_pkg::M_TUSER_BITS-1:0] m_tuser
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat shown after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // an empty table reports slot 0 and health 0
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == nidt_pkg::STATUS_NONE) |-> (m_tdata == '0))
    else $error("no-instance result carries data");

  // a destroyed entry never reports positive health
  a_destroyed_health: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == nidt_pkg::STATUS_DESTROYED) ||
                 (m_tuser == nidt_pkg::STATUS_ALREADY))
    |-> (m_tdata[31] || (m_tdata[31:8] == '0)))
    else $error("destroyed entry with positive health");

  // a damaged survivor keeps positive health
  a_damaged_health: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == nidt_pkg::STATUS_DAMAGED)
    |-> (!m_tdata[31] && (m_tdata[31:8] != '0)))
    else $error("damaged entry without positive health");

endmodule

bind nearest_instance_damage_table nidt_checker u_nidt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* dv/tb_nearest_instance_damage_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_instance_damage_table
// Self-checking bench for the nearest instance damage table.
// A short directed plan runs first: hits on an empty table, loads at the
// coordinate extremes, equal-distance ties, destroying and already destroyed
// hits, and both start health extremes. Random phases follow. Each phase sets
// its own instance count and start health, loads any entry the scan would
// reach that was never written, and then mixes loads with hits, most aimed near
// the stored entries. Every result beat is checked in order against a
// behavioral copy of the table that is kept inside the bench.
// ----------------------------------------------------------------------------
module tb_nearest_instance_damage_table;

  localparam logic   ACT_LOAD     = 1'b0;
  localparam logic   ACT_HIT      = 1'b1;
  localparam int     CYCLE_LIMIT  = 3000000;
  localparam int     PARK_CYCLES  = 600;
  localparam int     DRAIN_CYCLES = nidt_pkg::MAX_INSTANCES + 40;
  localparam int     NUM_PHASES   = 11;
  localparam longint HEALTH_FLOOR = -(longint'(1) << (nidt_pkg::HEALTH_BITS - 1));

  localparam logic [nidt_pkg::COORD_BITS-1:0]  C_MAX =
    {1'b0, {(nidt_pkg::COORD_BITS-1){1'b1}}};
  localparam logic [nidt_pkg::COORD_BITS-1:0]  C_MIN =
    {1'b1, {(nidt_pkg::COORD_BITS-1){1'b0}}};
  localparam logic [nidt_pkg::DAMAGE_BITS-1:0] D_MAX = '1;
  localparam logic [nidt_pkg::CFG_BITS-1:0]    H_MAX = '1;

  typedef enum {STEP_ITEM, STEP_WRITE} step_kind_t;

  // one row of the directed plan
  typedef struct {
    step_kind_t                    kind;
    nidt_pkg::cfg_index_t          reg_sel;
    logic [nidt_pkg::CFG_BITS-1:0] reg_val;
    nidt_pkg::item_t               item;
    bit                            typed;
    nidt_pkg::result_t             want;
  } plan_row_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [nidt_pkg::S_TDATA_BITS-1:0] s_tdata;
  logic                              s_tuser;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [nidt_pkg::M_TDATA_BITS-1:0] m_tdata;
  logic [nidt_pkg::M_TUSER_BITS-1:0] m_tuser;
  logic                              cfg_we;
  logic [0:0]                        cfg_index;
  logic [nidt_pkg::CFG_BITS-1:0]     cfg_data;

  // bench copy of the table and its registers
  logic signed [nidt_pkg::COORD_BITS-1:0]  tbl_x      [nidt_pkg::MAX_INSTANCES];
  logic signed [nidt_pkg::COORD_BITS-1:0]  tbl_y      [nidt_pkg::MAX_INSTANCES];
  logic signed [nidt_pkg::COORD_BITS-1:0]  tbl_z      [nidt_pkg::MAX_INSTANCES];
  logic signed [nidt_pkg::HEALTH_BITS-1:0] tbl_health [nidt_pkg::MAX_INSTANCES];
  bit                                      tbl_written[nidt_pkg::MAX_INSTANCES];
  logic [nidt_pkg::COUNT_BITS-1:0]         scan_count   = '0;
  logic [nidt_pkg::START_BITS-1:0]         spawn_health = 23'd25600;

  nidt_pkg::result_t pending_results [$];
  nidt_pkg::result_t want_beat;
  plan_row_t         plan [$];
  int                fail_count  = 0;
  int                cycle_count = 0;
  bit                park_req    = 1'b0;
  bit                gapless     = 1'b0;
  logic              rx_level    = 1'b0;
  int                rx_left     = 0;
  int                rx_roll;

  // random phases: instance count, start health, item count, no sender gaps
  int phase_count   [NUM_PHASES] = '{1, 2, 7, 0, 16, 3, 256, 511, 12, 64, 5};
  int phase_health  [NUM_PHASES] = '{25600, 1, 3000, 25600, 8388607, 0, 51200,
                                     700, 1234567, 12800, 2560};
  int phase_items   [NUM_PHASES] = '{100, 100, 100, 30, 100, 50, 40, 30, 110,
                                     90, 110};
  bit phase_gapless [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0};

  nearest_instance_damage_table dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // load writes an entry, hit damages the nearest entry in the scan range
  function automatic nidt_pkg::result_t apply_to_table(nidt_pkg::item_t it);
    nidt_pkg::result_t res;
    int                n;
    int                i;
    int                winner;
    longint            dx;
    longint            dy;
    longint            dz;
    longint            span;
    longint            best;
    longint            hp;
    res.status       = nidt_pkg::STATUS_LOADED;
    res.closest_slot = it.slot;
    res.health_left  = '0;
    if (it.is_hit == ACT_LOAD) begin
      tbl_x[it.slot]       = it.pos_x;
      tbl_y[it.slot]       = it.pos_y;
      tbl_z[it.slot]       = it.pos_z;
      tbl_health[it.slot]  = {1'b0, spawn_health};
      tbl_written[it.slot] = 1'b1;
      res.health_left      = {1'b0, spawn_health};
    end else begin
      n = (scan_count > nidt_pkg::MAX_INSTANCES) ? nidt_pkg::MAX_INSTANCES :
          int'(scan_count);
      res.status       = nidt_pkg::STATUS_NONE;
      res.closest_slot = '0;
      if (n != 0) begin
        winner = 0;
        best   = 0;
        // exact squared distance, first index wins ties
        for (i = 0; i < n; i++) begin
          dx   = longint'($signed(it.pos_x)) - longint'(tbl_x[i]);
          dy   = longint'($signed(it.pos_y)) - longint'(tbl_y[i]);
          dz   = longint'($signed(it.pos_z)) - longint'(tbl_z[i]);
          span = dx * dx + dy * dy + dz * dz;
          if (i == 0 || span < best) begin
            best   = span;
            winner = i;
          end
        end
        hp = longint'(tbl_health[winner]);
        if (hp <= 0) begin
          res.status = nidt_pkg::STATUS_ALREADY;
        end else begin
          hp = hp - longint'(it.damage);
          if (hp < HEALTH_FLOOR) hp = HEALTH_FLOOR;
          tbl_health[winner] = hp[nidt_pkg::HEALTH_BITS-1:0];
          res.status = (hp <= 0) ? nidt_pkg::STATUS_DESTROYED : nidt_pkg::STATUS_DAMAGED;
        end
        res.closest_slot = winner[nidt_pkg::SLOT_BITS-1:0];
        res.health_left  = hp[nidt_pkg::HEALTH_BITS-1:0];
      end
    end
    return res;
  endfunction

  // full range, small values near the origin for ties, or an extreme
  function automatic logic [nidt_pkg::COORD_BITS-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return nidt_pkg::COORD_BITS'($urandom());
    if (r < 7) return nidt_pkg::COORD_BITS'($urandom_range(0, 8) - 4);
    if (r == 7) return C_MIN;
    if (r == 8) return C_MAX;
    return '1;
  endfunction

  function automatic nidt_pkg::item_t random_item(int live);
    nidt_pkg::item_t it;
    int              pick;
    int              j;
    it.is_hit = ($urandom_range(0, 99) < 62) ? ACT_HIT : ACT_LOAD;
    if (live > 0 && $urandom_range(0, 99) < 70)
      it.slot = nidt_pkg::SLOT_BITS'($urandom_range(0, live - 1));
    else
      it.slot = nidt_pkg::SLOT_BITS'($urandom());
    it.pos_x = pick_coord();
    it.pos_y = pick_coord();
    it.pos_z = pick_coord();
    // most hits land close to a stored entry
    if (it.is_hit == ACT_HIT && live > 0 && $urandom_range(0, 99) < 55) begin
      j        = $urandom_range(0, live - 1);
      it.pos_x = nidt_pkg::COORD_BITS'(tbl_x[j] + $urandom_range(0, 6) - 3);
      it.pos_y = nidt_pkg::COORD_BITS'(tbl_y[j] + $urandom_range(0, 6) - 3);
      it.pos_z = nidt_pkg::COORD_BITS'(tbl_z[j] + $urandom_range(0, 6) - 3);
    end
    pick = $urandom_range(0, 9);
    if (pick < 4)
      it.damage = nidt_pkg::DAMAGE_BITS'($urandom_range(0, spawn_health / 3 + 1));
    else if (pick < 6)  it.damage = nidt_pkg::DAMAGE_BITS'($urandom_range(0, 255));
    else if (pick < 8)  it.damage = nidt_pkg::DAMAGE_BITS'($urandom());
    else if (pick == 8) it.damage = '0;
    else                it.damage = D_MAX;
    return it;
  endfunction

  function automatic plan_row_t item_row(logic act, int slot,
                                         logic [nidt_pkg::COORD_BITS-1:0] x,
                                         logic [nidt_pkg::COORD_BITS-1:0] y,
                                         logic [nidt_pkg::COORD_BITS-1:0] z,
                                         logic [nidt_pkg::DAMAGE_BITS-1:0] dmg,
                                         bit typed,
                                         nidt_pkg::status_t st, int es,
                                         logic [nidt_pkg::HEALTH_BITS-1:0] eh);
    plan_row_t row;
    row.kind              = STEP_ITEM;
    row.reg_sel           = nidt_pkg::CFG_INSTANCE_COUNT;
    row.reg_val           = '0;
    row.item.is_hit       = act;
    row.item.slot         = nidt_pkg::SLOT_BITS'(slot);
    row.item.pos_x        = x;
    row.item.pos_y        = y;
    row.item.pos_z        = z;
    row.item.damage       = dmg;
    row.typed             = typed;
    row.want.status       = st;
    row.want.closest_slot = nidt_pkg::SLOT_BITS'(es);
    row.want.health_left  = eh;
    return row;
  endfunction

  function automatic plan_row_t write_row(nidt_pkg::cfg_index_t sel,
                                          logic [nidt_pkg::CFG_BITS-1:0] val);
    plan_row_t row;
    row         = item_row(ACT_LOAD, 0, '0, '0, '0, '0, 1'b0,
                           nidt_pkg::STATUS_LOADED, 0, '0);
    row.kind    = STEP_WRITE;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // offer one beat after a random gap, predict it at acceptance
  task automatic offer_item(nidt_pkg::item_t it, bit typed, nidt_pkg::result_t want);
    int                r;
    int                gap;
    bit                took;
    nidt_pkg::result_t predicted;
    r = $urandom_range(0, 99);
    if (gapless || r < 55) gap = 0;
    else if (r < 88)       gap = $urandom_range(1, 3);
    else if (r < 97)       gap = $urandom_range(4, 20);
    else                   gap = $urandom_range(30, 90);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.is_hit;
    s_tdata  <= {1'b0, it.damage, it.pos_z, it.pos_y, it.pos_x, it.slot};
    do begin
      @(negedge clk);
      took = s_tready;
      if (took) begin
        predicted = apply_to_table(it);
        pending_results.push_back(typed ? want : predicted);
      end
      @(posedge clk);
    end while (!took);
  endtask

  // stop offering and wait for every pending result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(nidt_pkg::cfg_index_t sel, logic [nidt_pkg::CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == nidt_pkg::CFG_INSTANCE_COUNT) scan_count = val[nidt_pkg::COUNT_BITS-1:0];
    else spawn_health = val[nidt_pkg::START_BITS-1:0];
    @(posedge clk);
  endtask

  // receiver: random ready runs and stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (park_req) begin
        park_req = 1'b0;
        rx_level = 1'b0;
        rx_left  = PARK_CYCLES;
      end else if (rx_left != 0) begin
        rx_left--;
      end else begin
        rx_level = !rx_level;
        rx_roll  = $urandom_range(0, 99);
        if (rx_level)
          rx_left = (rx_roll < 60) ? $urandom_range(0, 6) :
                    (rx_roll < 92) ? $urandom_range(7, 40) : $urandom_range(100, 300);
        else
          rx_left = (rx_roll < 65) ? $urandom_range(0, 1) :
                    (rx_roll < 93) ? $urandom_range(2, 12) : $urandom_range(20, 90);
      end
      m_tready <= rx_level;
    end
  end

  // result check, sampled at the falling edge before the accepting edge
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d slot %0d health %0d",
                 $time, m_tuser, m_tdata[nidt_pkg::SLOT_BITS-1:0],
                 $signed(m_tdata[nidt_pkg::SLOT_BITS +: nidt_pkg::HEALTH_BITS]));
        fail_count++;
      end else begin
        want_beat = pending_results.pop_front();
        if (m_tuser !== want_beat.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want_beat.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[nidt_pkg::SLOT_BITS-1:0] !== want_beat.closest_slot) begin
          $display("%0t: closest_slot expected %0d actual %0d", $time,
                   want_beat.closest_slot, m_tdata[nidt_pkg::SLOT_BITS-1:0]);
          fail_count++;
        end
        if (m_tdata[nidt_pkg::SLOT_BITS +: nidt_pkg::HEALTH_BITS] !==
            want_beat.health_left) begin
          $display("%0t: health_left expected %0d actual %0d", $time,
                   $signed(want_beat.health_left),
                   $signed(m_tdata[nidt_pkg::SLOT_BITS +: nidt_pkg::HEALTH_BITS]));
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int              k;
    int              p;
    int              live;
    int              fill_slot;
    nidt_pkg::item_t fill;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tuser   = ACT_LOAD;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = nidt_pkg::CFG_INSTANCE_COUNT;
    cfg_data  = '0;

    // empty table after reset
    plan.push_back(item_row(ACT_HIT, 0, '0, '0, '0, 23'd100, 1,
                            nidt_pkg::STATUS_NONE, 0, '0));
    plan.push_back(item_row(ACT_HIT, 255, C_MIN, C_MAX, C_MIN, D_MAX, 1,
                            nidt_pkg::STATUS_NONE, 0, '0));
    // loads at the extremes, two entries sharing a position
    plan.push_back(item_row(ACT_LOAD, 0, C_MAX, C_MAX, C_MAX, '0, 1,
                            nidt_pkg::STATUS_LOADED, 0, 24'd25600));
    plan.push_back(item_row(ACT_LOAD, 1, C_MIN, C_MIN, C_MIN, D_MAX, 1,
                            nidt_pkg::STATUS_LOADED, 1, 24'd25600));
    plan.push_back(item_row(ACT_LOAD, 2, '0, '0, '0, 23'd7, 1,
                            nidt_pkg::STATUS_LOADED, 2, 24'd25600));
    plan.push_back(item_row(ACT_LOAD, 3, '0, '0, '0, 23'd7, 1,
                            nidt_pkg::STATUS_LOADED, 3, 24'd25600));
    plan.push_back(item_row(ACT_LOAD, 255, '1, '1, '1, 23'd1, 1,
                            nidt_pkg::STATUS_LOADED, 255, 24'd25600));
    plan.push_back(write_row(nidt_pkg::CFG_INSTANCE_COUNT, 23'd4));
    // tie between entries 2 and 3 goes to the lower index
    plan.push_back(item_row(ACT_HIT, 9, 24'd1, 24'd1, 24'd1, '0, 1,
                            nidt_pkg::STATUS_DAMAGED, 2, 24'd25600));
    plan.push_back(item_row(ACT_HIT, 0, C_MAX, C_MAX, C_MAX, 23'd25600, 1,
                            nidt_pkg::STATUS_DESTROYED, 0, '0));
    plan.push_back(item_row(ACT_HIT, 0, C_MAX, C_MAX, C_MAX, 23'd5, 1,
                            nidt_pkg::STATUS_ALREADY, 0, '0));
    plan.push_back(item_row(ACT_HIT, 1, C_MIN, C_MIN, C_MIN, D_MAX, 1,
                            nidt_pkg::STATUS_DESTROYED, 1, -24'sd8363007));
    plan.push_back(item_row(ACT_HIT, 1, C_MIN, C_MIN, C_MIN, 23'd1, 1,
                            nidt_pkg::STATUS_ALREADY, 1, -24'sd8363007));
    plan.push_back(item_row(ACT_HIT, 2, '0, '0, '1, 23'd25599, 1,
                            nidt_pkg::STATUS_DAMAGED, 2, 24'd1));
    plan.push_back(item_row(ACT_HIT, 2, '0, 24'd1, '0, 23'd1, 1,
                            nidt_pkg::STATUS_DESTROYED, 2, '0));
    plan.push_back(item_row(ACT_HIT, 3, '1, '0, '0, 23'd1, 1,
                            nidt_pkg::STATUS_ALREADY, 2, '0));
    // start health extremes
    plan.push_back(write_row(nidt_pkg::CFG_START_HEALTH, '0));
    plan.push_back(item_row(ACT_LOAD, 4, 24'd100, -24'sd100, 24'd50, '0, 1,
                            nidt_pkg::STATUS_LOADED, 4, '0));
    plan.push_back(write_row(nidt_pkg::CFG_START_HEALTH, H_MAX));
    plan.push_back(item_row(ACT_LOAD, 5, -24'sd5, 24'd7, -24'sd9, '0, 1,
                            nidt_pkg::STATUS_LOADED, 5, 24'd8388607));
    plan.push_back(write_row(nidt_pkg::CFG_INSTANCE_COUNT, 23'd6));
    plan.push_back(item_row(ACT_HIT, 5, -24'sd5, 24'd7, -24'sd9, D_MAX, 1,
                            nidt_pkg::STATUS_DESTROYED, 5, '0));
    plan.push_back(item_row(ACT_HIT, 4, 24'd100, -24'sd100, 24'd50, 23'd3, 1,
                            nidt_pkg::STATUS_ALREADY, 4, '0));
    // far corners, checked by the predictor
    plan.push_back(item_row(ACT_HIT, 0, C_MAX, C_MIN, C_MAX, 23'd1234, 0,
                            nidt_pkg::STATUS_LOADED, 0, '0));
    plan.push_back(item_row(ACT_HIT, 0, C_MIN, C_MAX, '0, 23'd77, 0,
                            nidt_pkg::STATUS_LOADED, 0, '0));
    plan.push_back(write_row(nidt_pkg::CFG_INSTANCE_COUNT, '0));
    plan.push_back(item_row(ACT_HIT, 0, 24'd3, 24'd3, 24'd3, 23'd9, 1,
                            nidt_pkg::STATUS_NONE, 0, '0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed plan
    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].kind == STEP_WRITE) begin
        drain_results();
        write_reg(plan[k].reg_sel, plan[k].reg_val);
      end else begin
        offer_item(plan[k].item, plan[k].typed, plan[k].want);
      end
    end

    // random phases
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_reg(nidt_pkg::CFG_INSTANCE_COUNT, nidt_pkg::CFG_BITS'(phase_count[p]));
      write_reg(nidt_pkg::CFG_START_HEALTH, nidt_pkg::CFG_BITS'(phase_health[p]));
      live    = (phase_count[p] > nidt_pkg::MAX_INSTANCES) ? nidt_pkg::MAX_INSTANCES :
                phase_count[p];
      gapless = phase_gapless[p];
      if (p == 2 || p == 8) park_req = 1'b1;
      // every entry the scan reaches must be loaded first
      for (fill_slot = 0; fill_slot < live; fill_slot++) begin
        if (!tbl_written[fill_slot]) begin
          fill        = random_item(0);
          fill.is_hit = ACT_LOAD;
          fill.slot   = nidt_pkg::SLOT_BITS'(fill_slot);
          offer_item(fill, 1'b0, '0);
        end
      end
      for (k = 0; k < phase_items[p]; k++)
        offer_item(random_item(live), 1'b0, '0);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
